// ----- design/ppmv_pkg.sv -----
`default_nettype none
package ppmv_pkg;

    localparam int STORE_BYTES = 262144;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int PIX_W       = 20;
    localparam int WDATA_W     = 8;
    localparam int PIXEL_W     = 4;
    localparam int BYTE_W      = 8;
    localparam int SHIFT_W     = 3;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic MODE_4BPP = 1'b0;
    localparam logic MODE_2BPP = 1'b1;

    localparam logic [PIXEL_W-1:0] MASK_4BPP = 4'hf;
    localparam logic [PIXEL_W-1:0] MASK_2BPP = 4'h3;

    typedef struct packed {
        logic              busy;
        logic [ADDR_W-1:0] addr;
    } clr_t;

    function automatic logic [ADDR_W-1:0] byte_index(input logic [PIX_W-1:0] raw);
        logic [PIX_W:0] masked;
        masked = {1'b0, raw} & (PIX_W+1)'(STORE_BYTES - 1);
        if (masked >= (PIX_W+1)'(STORE_BYTES)) begin
            return '0;
        end
        return masked[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/packed_pixel_memory_view_top.sv -----
// a read result goes via stage 1 and the output register; a full, unready m_ side stalls a read
// throughput: one access per unstalled cycle, set by the read-modify-write pass on the byte ram
// a write to the byte a following access reads is forwarded, so back-to-back hazards cost nothing
// reset: synchronous, active low; the byte ram is then zeroed one byte a cycle,
// all 262144 bytes, with s_tready low; cfg writes are taken during that pass
`default_nettype none
module packed_pixel_memory_view_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_wr_data,   // bitmap_mode
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ppmv_pkg::S_TDATA_W-1:0] s_tdata,       // pixel_address, write_data
    input  wire logic                           s_tuser,       // kind
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [ppmv_pkg::M_TDATA_W-1:0] m_tdata        // read_pixel
);
    import ppmv_pkg::*;

    clr_t clr;

    logic mode_reg;

    logic                 st1_valid_reg;
    logic                 st1_kind_reg;
    logic [ADDR_W-1:0]    st1_addr_reg;
    logic [SHIFT_W-1:0]   st1_shift_reg;
    logic [PIXEL_W-1:0]   st1_mask_reg;
    logic [WDATA_W-1:0]   st1_wdata_reg;

    logic                 fwd_valid_reg;
    logic [BYTE_W-1:0]    fwd_data_reg;

    logic                 out_valid_reg;
    logic [PIXEL_W-1:0]   out_pixel_reg;

    logic [PIX_W-1:0]     in_pix;
    logic [WDATA_W-1:0]   in_wdata;
    logic [ADDR_W-1:0]    in_addr;
    logic [SHIFT_W-1:0]   in_shift;
    logic [PIXEL_W-1:0]   in_mask;

    logic [BYTE_W-1:0]    ram_rdata;
    logic [BYTE_W-1:0]    cur_byte;
    logic [BYTE_W-1:0]    field_mask;
    logic [BYTE_W-1:0]    new_byte;
    logic [BYTE_W-1:0]    shifted;
    logic                 st1_write;
    logic                 stall;
    logic                 s_fire;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [BYTE_W-1:0]    ram_wdata;

    ppmv_clr u_clr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (clr)
    );

    assign in_pix   = s_tdata[PIX_W-1:0];
    assign in_wdata = s_tdata[PIX_W +: WDATA_W];

    always_comb begin
        if (mode_reg == MODE_4BPP) begin
            in_addr  = byte_index({1'b0, in_pix[PIX_W-1:1]});
            in_shift = {in_pix[0], 2'b00};
            in_mask  = MASK_4BPP;
        end else begin
            in_addr  = byte_index({2'b00, in_pix[PIX_W-1:2]});
            in_shift = {in_pix[1:0], 1'b0};
            in_mask  = MASK_2BPP;
        end
    end

    assign st1_write = st1_valid_reg && (st1_kind_reg == KIND_WRITE);
    assign stall     = st1_valid_reg && (st1_kind_reg == KIND_READ)
                       && out_valid_reg && !m_tready;
    assign s_tready  = !clr.busy && !stall;
    assign s_fire    = s_tvalid && s_tready;

    assign cur_byte   = fwd_valid_reg ? fwd_data_reg : ram_rdata;
    assign field_mask = {4'h0, st1_mask_reg} << st1_shift_reg;
    assign new_byte   = (cur_byte & ~field_mask)
                        | ({4'h0, st1_wdata_reg[PIXEL_W-1:0] & st1_mask_reg} << st1_shift_reg);
    assign shifted    = cur_byte >> st1_shift_reg;

    assign ram_we    = clr.busy || st1_write;
    assign ram_waddr = clr.busy ? clr.addr : st1_addr_reg;
    assign ram_wdata = clr.busy ? '0 : new_byte;

    ppmv_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_fire),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_4BPP;
            st1_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (!stall) begin
                st1_valid_reg <= s_fire;
            end
            if (s_fire) begin
                fwd_valid_reg <= st1_write && (st1_addr_reg == in_addr);
            end
            if (st1_valid_reg && (st1_kind_reg == KIND_READ) && !stall) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_kind_reg  <= s_tuser;
            st1_addr_reg  <= in_addr;
            st1_shift_reg <= in_shift;
            st1_mask_reg  <= in_mask;
            st1_wdata_reg <= in_wdata;
            fwd_data_reg  <= new_byte;
        end
        if (st1_valid_reg && (st1_kind_reg == KIND_READ) && !stall) begin
            out_pixel_reg <= shifted[PIXEL_W-1:0] & st1_mask_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W-PIXEL_W)'(0), out_pixel_reg};

endmodule
`default_nettype wire

// ----- design/ppmv_ram.sv -----
`default_nettype none
module ppmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- design/ppmv_clr.sv -----
`default_nettype none
module ppmv_clr (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    output ppmv_pkg::clr_t     clr
);
    import ppmv_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    always_comb begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        if (busy_reg) begin
            addr_next = addr_reg + ADDR_W'(1);
            if (addr_reg == ADDR_W'(STORE_BYTES - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign clr.busy = busy_reg;
    assign clr.addr = addr_reg;

endmodule
`default_nettype wire
